// ===== src/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdc_pkg: shared constants for the proximity dimmer controller
// Register indexes, reset values, mode codes and fixed widths.
// ----------------------------------------------------------------------------
package pdc_pkg;

	// Fixed field widths
	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned TIME_W  = 16;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THRESHOLD   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAR_THRESHOLD    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SETUP_DELAY_MS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SETUP_RAMP_MS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_RAMP_MS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SETUP_TIMEOUT_MS = 3'd5;

	// Register reset values
	localparam logic [LEVEL_W-1:0] RST_NEAR_THRESHOLD   = 8'd125;
	localparam logic [LEVEL_W-1:0] RST_FAR_THRESHOLD    = 8'd160;
	localparam logic [TIME_W-1:0]  RST_SETUP_DELAY_MS   = 16'd1000;
	localparam logic [TIME_W-1:0]  RST_SETUP_RAMP_MS    = 16'd7000;
	localparam logic [TIME_W-1:0]  RST_SWITCH_RAMP_MS   = 16'd1000;
	localparam logic [TIME_W-1:0]  RST_SETUP_TIMEOUT_MS = 16'd20000;

	// Mode codes
	localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FADE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SETUP = 2'd2;

	// Input command codes
	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// Setup ramp constants
	localparam logic [TIME_W-1:0]  SETUP_PAUSE_MS = 16'd1000;
	localparam logic [LEVEL_W-1:0] FULL_LEVEL     = 8'd255;

	// Ramp divider: dividend is elapsed time times level
	localparam int unsigned NUM_W     = TIME_W + LEVEL_W;
	localparam int unsigned DIV_CNT_W = $clog2(NUM_W + 1);

endpackage

// ===== src/proximity_dimmer_controller.sv =====
// ----------------------------------------------------------------------------
// proximity_dimmer_controller: hand-hold dimmer with fade and setup ramp
// Times hand holds from proximity samples, toggles the light with a linear
// fade, runs a brightness setup ramp on long holds and reports the duty level.
// ----------------------------------------------------------------------------
// Every accepted beat gives exactly one result beat. A tick beat (cmd = 0)
// bumps the millisecond count and goes straight to the output step. A
// sample beat walks a small sequencer: hysteresis, toggle, release, setup
// entry and ramp mapping, one step a cycle. While a fade or setup ramp is
// active the level is mapped by one multiply and one shared restoring
// divider that retires one quotient bit a cycle, one for each bit of the
// dividend. in_stall stays high from acceptance until the result is loaded
// into the output register, which may also wait on out_stall, so a new beat
// is taken only once the last one is through.
module proximity_dimmer_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            cmd,
	input  logic [pdc_pkg::LEVEL_W-1:0]     sensor_level,
	// output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [pdc_pkg::LEVEL_W-1:0]     pwm_level,
	output logic [pdc_pkg::MODE_W-1:0]      mode,
	output logic                            light_on,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [pdc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pdc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pdc_pkg::*;

	// Sequencer codes
	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_HYST    = 4'd1;
	localparam logic [3:0] ST_TOGGLE  = 4'd2;
	localparam logic [3:0] ST_RELEASE = 4'd3;
	localparam logic [3:0] ST_ENTRY   = 4'd4;
	localparam logic [3:0] ST_MAP     = 4'd5;
	localparam logic [3:0] ST_MUL     = 4'd6;
	localparam logic [3:0] ST_DIV     = 4'd7;
	localparam logic [3:0] ST_APPLY   = 4'd8;
	localparam logic [3:0] ST_OUT     = 4'd9;

	localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(NUM_W);

	// Configuration registers
	logic [LEVEL_W-1:0] near_thr_q, far_thr_q;
	logic [TIME_W-1:0]  setup_delay_q, setup_ramp_q, switch_ramp_q, setup_timeout_q;

	// Block state
	logic [3:0]         state_q;
	logic [TIME_W-1:0]  ms_q, hold_start_q, hold_time_q, phase_start_q;
	logic [MODE_W-1:0]  mode_q;
	logic               light_q;
	logic [LEVEL_W-1:0] max_level_q, last_setup_q, duty_q;
	logic [LEVEL_W-1:0] sample_q;

	// Ramp mapping datapath
	logic [TIME_W-1:0]    el_q, span_q;
	logic [LEVEL_W-1:0]   top_q;
	logic [TIME_W+1:0]    ramp_end_q;
	logic [NUM_W-1:0]     num_q;
	logic [TIME_W-1:0]    rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	// Output register
	logic               out_valid_q;
	logic [LEVEL_W-1:0] out_level_q;
	logic [MODE_W-1:0]  out_mode_q;
	logic               out_light_q;

	// Hysteresis step
	logic [TIME_W-1:0] hs_new;
	assign hs_new = (hold_start_q == '0) ? ms_q : hold_start_q;

	// Setup entry window
	logic [TIME_W:0] entry_hi;
	assign entry_hi = {1'b0, setup_delay_q} + {1'b0, setup_ramp_q};

	// Mapping step operands
	logic [TIME_W-1:0] el_now;
	assign el_now = ms_q - phase_start_q;

	// Divider step
	logic [TIME_W:0] div_shift;
	logic            div_ge;
	assign div_shift = {rem_q, num_q[NUM_W-1]};
	assign div_ge    = div_shift >= {1'b0, span_q};

	// Capped level and phase end compares
	logic [LEVEL_W-1:0] level_cap, setup_v, fade_v;
	logic [TIME_W+2:0]  timeout_end;
	logic [TIME_W:0]    fade_end;
	logic               past_ramp, past_timeout, past_fade;
	always_comb begin
		if (span_q == '0 || num_q > NUM_W'(top_q))
			level_cap = top_q;
		else
			level_cap = num_q[LEVEL_W-1:0];
		setup_v      = (el_q < SETUP_PAUSE_MS) ? '0 : level_cap;
		fade_v       = light_q ? level_cap : (max_level_q - level_cap);
		timeout_end  = {1'b0, ramp_end_q} + {3'b000, setup_timeout_q};
		fade_end     = {1'b0, phase_start_q} + {1'b0, switch_ramp_q};
		past_ramp    = {2'b00, ms_q} > ramp_end_q;
		past_timeout = {3'b000, ms_q} > timeout_end;
		past_fade    = {1'b0, ms_q} > fade_end;
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign pwm_level = out_level_q;
	assign mode      = out_mode_q;
	assign light_on  = out_light_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_thr_q      <= RST_NEAR_THRESHOLD;
			far_thr_q       <= RST_FAR_THRESHOLD;
			setup_delay_q   <= RST_SETUP_DELAY_MS;
			setup_ramp_q    <= RST_SETUP_RAMP_MS;
			switch_ramp_q   <= RST_SWITCH_RAMP_MS;
			setup_timeout_q <= RST_SETUP_TIMEOUT_MS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NEAR_THRESHOLD:   near_thr_q      <= cfg_data[LEVEL_W-1:0];
				CFG_FAR_THRESHOLD:    far_thr_q       <= cfg_data[LEVEL_W-1:0];
				CFG_SETUP_DELAY_MS:   setup_delay_q   <= cfg_data[TIME_W-1:0];
				CFG_SETUP_RAMP_MS:    setup_ramp_q    <= cfg_data[TIME_W-1:0];
				CFG_SWITCH_RAMP_MS:   switch_ramp_q   <= cfg_data[TIME_W-1:0];
				CFG_SETUP_TIMEOUT_MS: setup_timeout_q <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ms_q          <= '0;
			hold_start_q  <= '0;
			hold_time_q   <= '0;
			phase_start_q <= '0;
			mode_q        <= MODE_IDLE;
			light_q       <= 1'b0;
			max_level_q   <= FULL_LEVEL;
			last_setup_q  <= '0;
			duty_q        <= '0;
			sample_q      <= '0;
			el_q          <= '0;
			span_q        <= '0;
			top_q         <= '0;
			ramp_end_q    <= '0;
			num_q         <= '0;
			rem_q         <= '0;
			div_cnt_q     <= '0;
			out_valid_q   <= 1'b0;
			out_level_q   <= '0;
			out_mode_q    <= MODE_IDLE;
			out_light_q   <= 1'b0;
		end else begin
			// result beat loaded by the output step, cleared once taken
			if (state_q == ST_OUT && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						sample_q <= sensor_level;
						if (cmd == CMD_TICK) begin
							ms_q    <= ms_q + 16'd1;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_HYST;
						end
					end
				end
				// hand present / far away
				ST_HYST: begin
					if (sample_q < near_thr_q) begin
						hold_start_q <= hs_new;
						hold_time_q  <= ms_q - hs_new;
					end else if (sample_q > far_thr_q) begin
						hold_start_q <= '0;
						hold_time_q  <= '0;
					end
					state_q <= ST_TOGGLE;
				end
				// any hold while idle starts an on/off fade
				ST_TOGGLE: begin
					if (hold_time_q != '0 && mode_q == MODE_IDLE) begin
						phase_start_q <= ms_q;
						light_q       <= !light_q;
						mode_q        <= MODE_FADE;
					end
					state_q <= ST_RELEASE;
				end
				// hand released during setup: commit the level
				ST_RELEASE: begin
					if (hold_time_q == '0 && mode_q == MODE_SETUP) begin
						mode_q <= MODE_IDLE;
						if (last_setup_q != '0)
							max_level_q <= last_setup_q;
						else
							duty_q <= max_level_q;
						light_q      <= 1'b1;
						hold_start_q <= '0;
						ms_q         <= '0;
					end
					state_q <= ST_ENTRY;
				end
				// long hold enters setup
				ST_ENTRY: begin
					if ({1'b0, setup_delay_q} < {1'b0, hold_time_q} &&
					    {1'b0, hold_time_q} < entry_hi && mode_q != MODE_SETUP) begin
						phase_start_q <= ms_q;
						mode_q        <= MODE_SETUP;
					end
					state_q <= ST_MAP;
				end
				// load mapping operands
				ST_MAP: begin
					el_q       <= el_now;
					ramp_end_q <= {2'b00, phase_start_q} + {2'b00, setup_ramp_q}
					              + {2'b00, SETUP_PAUSE_MS};
					if (mode_q == MODE_SETUP) begin
						span_q  <= setup_ramp_q;
						top_q   <= FULL_LEVEL;
						state_q <= ST_MUL;
					end else if (mode_q == MODE_FADE) begin
						span_q  <= switch_ramp_q;
						top_q   <= max_level_q;
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_MUL: begin
					num_q     <= NUM_W'(el_q) * NUM_W'(top_q);
					rem_q     <= '0;
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				// one quotient bit a cycle
				ST_DIV: begin
					rem_q     <= div_ge ? TIME_W'(div_shift - {1'b0, span_q})
					                    : div_shift[TIME_W-1:0];
					num_q     <= {num_q[NUM_W-2:0], div_ge};
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_STEPS - DIV_CNT_W'(1))
						state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (mode_q == MODE_SETUP) begin
						last_setup_q <= setup_v;
						// full level once the ramp has run out
						duty_q       <= past_ramp ? FULL_LEVEL : setup_v;
						if (past_ramp)
							max_level_q <= FULL_LEVEL;
						if (past_timeout) begin
							hold_start_q  <= '0;
							hold_time_q   <= '0;
							phase_start_q <= '0;
							mode_q        <= MODE_IDLE;
							light_q       <= 1'b0;
							ms_q          <= '0;
						end
					end else begin
						duty_q <= fade_v;
						if (past_fade) begin
							mode_q        <= MODE_IDLE;
							phase_start_q <= '0;
							ms_q          <= '0;
						end
					end
					state_q <= ST_OUT;
				end
				// hand the result to the output register
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_level_q <= duty_q;
						out_mode_q  <= mode_q;
						out_light_q <= light_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// a new result only follows the output step
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result beat raised outside output step");

	// an accepted beat always starts the sequencer
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_HYST || state_q == ST_OUT))
		else $error("accepted beat did not start the sequencer");

	// divider count stays within its steps
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_cnt_q < DIV_STEPS))
		else $error("divider ran past its last step");

	// the mapping runs only for fade or setup
	a_map_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (mode_q == MODE_FADE || mode_q == MODE_SETUP))
		else $error("ramp mapping started in idle mode");

	// reported mode is a defined code
	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_mode_q == MODE_IDLE || out_mode_q == MODE_FADE ||
		                 out_mode_q == MODE_SETUP))
		else $error("undefined mode reported");
`endif

endmodule
